### src/vpt_pkg.sv
// ---------------------------------------------------------------------------
// vpt_pkg - shared types and constants
// Register map, reset values and stage payload types for the vertex
// transform pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package vpt_pkg;

   localparam int NUM_REGS  = 8;
   localparam int IDX_W     = 3;
   localparam int REG_W     = 64;
   localparam int COORD_W   = 32;
   localparam int ACC_W     = 50;   // |sum| < 2^48, one spare bit
   localparam int MAG_W     = 48;
   localparam int NUM_W     = 64;   // magnitude shifted up by 16
   localparam int QUO_W     = 33;   // enough to see a clamp
   localparam int FRAC_W    = 16;

   localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
      64'h0000_0001_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000
   };

   typedef logic [NUM_REGS-1:0][REG_W-1:0] coef_bank_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] rem;
      logic [2:0][NUM_W-1:0] num;
      logic [2:0][QUO_W-1:0] quo;
      logic [MAG_W-1:0]      den;
      logic [2:0]            neg;
      logic [2:0]            ovf;
      logic                  wz;
   } div_type;

endpackage

`default_nettype wire

### src/vpt_mac.sv
// ---------------------------------------------------------------------------
// vpt_mac - matrix multiply front end
// Products, column sums, then magnitudes, signs and overflow check that
// seed the divider pipeline. Three register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module vpt_mac (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire vpt_pkg::coef_bank_type          coefs,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire logic [vpt_pkg::COORD_W-1:0]     in_x,
   input  wire logic [vpt_pkg::COORD_W-1:0]     in_y,
   input  wire logic [vpt_pkg::COORD_W-1:0]     in_z,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output vpt_pkg::div_type                     out_data
);
   import vpt_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   logic signed [63:0]      prod_ff [4][3];
   logic signed [63:0]      prod_in [4][3];
   logic signed [COORD_W-1:0] off_ff [4];
   logic signed [COORD_W-1:0] off_in [4];
   logic signed [ACC_W-1:0] acc_ff [4];
   logic signed [ACC_W-1:0] acc_in [4];
   logic signed [63:0]      sum [4];
   div_type                 seed_ff, seed_in;
   logic [MAG_W-1:0]        mag [4];
   logic [ACC_W-1:0]        neg_acc [4];

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // coefficient of row r, column c: register r*2 + c/2, half c%2
   function automatic logic signed [COORD_W-1:0] coef_at(coef_bank_type b, int r, int c);
      logic [REG_W-1:0] w;
      w = b[r*2 + c/2];
      return (c % 2 == 1) ? w[63:32] : w[31:0];
   endfunction

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         prod_in[c][0] = $signed(in_x) * coef_at(coefs, 0, c);
         prod_in[c][1] = $signed(in_y) * coef_at(coefs, 1, c);
         prod_in[c][2] = $signed(in_z) * coef_at(coefs, 2, c);
         off_in[c]     = coef_at(coefs, 3, c);
      end
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         // arithmetic shift is floor to Q16.16
         sum[c] = (prod_ff[c][0] >>> FRAC_W) + (prod_ff[c][1] >>> FRAC_W)
                + (prod_ff[c][2] >>> FRAC_W) + 64'(off_ff[c]);
         acc_in[c] = sum[c][ACC_W-1:0];
      end
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         neg_acc[c] = -acc_ff[c];
         mag[c] = acc_ff[c][ACC_W-1] ? neg_acc[c][MAG_W-1:0] : acc_ff[c][MAG_W-1:0];
      end
      seed_in     = '0;
      seed_in.den = mag[3];
      seed_in.wz  = (acc_ff[3] == '0);
      for (int c = 0; c < 3; c++) begin
         seed_in.neg[c] = acc_ff[c][ACC_W-1] ^ acc_ff[3][ACC_W-1];
         // quotient >= 2^33 when n >= d * 2^17
         seed_in.ovf[c] = {17'b0, mag[c]} >= {mag[3], 17'b0};
         seed_in.num[c] = {mag[c], 16'b0};
         seed_in.rem[c] = {17'b0, mag[c][MAG_W-1:17]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         prod_ff <= prod_in;
         off_ff  <= off_in;
      end
      if (rdy2 && v1_ff) acc_ff  <= acc_in;
      if (rdy3 && v2_ff) seed_ff <= seed_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = seed_ff;

endmodule

`default_nettype wire

### src/vpt_div_step.sv
// ---------------------------------------------------------------------------
// vpt_div_step - one restoring division stage
// Produces quotient bit BIT for all three lanes against the shared w.
// ---------------------------------------------------------------------------
`default_nettype none

module vpt_div_step #(
   parameter int BIT = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire vpt_pkg::div_type  in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output vpt_pkg::div_type       out_data
);
   import vpt_pkg::*;

   logic    valid_ff;
   div_type data_ff, data_in;
   logic [MAG_W:0] r2 [3];
   logic [MAG_W:0] diff [3];

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in = in_data;
      for (int c = 0; c < 3; c++) begin
         r2[c]   = {in_data.rem[c], in_data.num[c][BIT]};
         diff[c] = r2[c] - {1'b0, in_data.den};
         if (r2[c] >= {1'b0, in_data.den}) begin
            data_in.rem[c]      = diff[c][MAG_W-1:0];
            data_in.quo[c][BIT] = 1'b1;
         end else begin
            data_in.rem[c]      = r2[c][MAG_W-1:0];
            data_in.quo[c][BIT] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### src/vpt_sat.sv
// ---------------------------------------------------------------------------
// vpt_sat - sign, clamp and output register
// Applies the quotient sign, clamps to 32 bits and handles w equal to zero.
// ---------------------------------------------------------------------------
`default_nettype none

module vpt_sat (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire vpt_pkg::div_type             in_data,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic [vpt_pkg::COORD_W-1:0]       out_x,
   output logic [vpt_pkg::COORD_W-1:0]       out_y,
   output logic [vpt_pkg::COORD_W-1:0]       out_z,
   output logic                              out_w_zero,
   output logic                              out_saturated
);
   import vpt_pkg::*;

   logic valid_ff;
   logic [COORD_W-1:0] res_ff [3];
   logic [COORD_W-1:0] res_in [3];
   logic wz_ff, sat_ff, sat_in;
   logic [QUO_W-1:0] q;
   logic [QUO_W-1:0] nq;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      sat_in = 1'b0;
      for (int c = 0; c < 3; c++) begin
         q  = in_data.quo[c];
         nq = -q;
         if (!in_data.neg[c]) begin
            if (in_data.ovf[c] || q > 33'h0_7FFF_FFFF) begin
               res_in[c] = 32'h7FFF_FFFF;
               sat_in    = 1'b1;
            end else begin
               res_in[c] = q[COORD_W-1:0];
            end
         end else begin
            if (in_data.ovf[c] || q > 33'h0_8000_0000) begin
               res_in[c] = 32'h8000_0000;
               sat_in    = 1'b1;
            end else begin
               res_in[c] = nq[COORD_W-1:0];
            end
         end
         if (in_data.wz) res_in[c] = '0;
      end
      if (in_data.wz) sat_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         res_ff <= res_in;
         wz_ff  <= in_data.wz;
         sat_ff <= sat_in;
      end
   end

   assign out_valid     = valid_ff;
   assign out_x         = res_ff[0];
   assign out_y         = res_ff[1];
   assign out_z         = res_ff[2];
   assign out_w_zero    = wz_ff;
   assign out_saturated = sat_ff;

endmodule

`default_nettype wire

### src/projective_vertex_transform.sv
// ---------------------------------------------------------------------------
// projective_vertex_transform - 4x4 vertex transform with perspective divide
// Point (x,y,z,1) in Q16.16 times a programmable matrix, then X,Y,Z over W.
//
// Channels: req_* takes one point per item, rsp_* returns one result item.
// Both use valid/stall; an item moves when valid is high and stall is low.
// csr_* writes one 64-bit coefficient register pair per cycle; write only
// while the pipeline is empty.
// Pipeline: 3 multiply/sum stages, 33 divider stages, one quotient bit each,
// and 1 sign/clamp stage that is also the output register. Throughput: one
// item per cycle while rsp_stall is low.
// Every stage holds its own valid bit and moves when the next stage is free,
// so a stall on rsp fills bubbles before req_stall rises; nothing is lost.
// Reset clears all valid bits and loads the default matrix from REG_RESET.
// ---------------------------------------------------------------------------
`default_nettype none

module projective_vertex_transform (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [vpt_pkg::IDX_W-1:0]     csr_index,
   input  wire logic [vpt_pkg::REG_W-1:0]     csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [vpt_pkg::COORD_W-1:0]   req_in_x,
   input  wire logic [vpt_pkg::COORD_W-1:0]   req_in_y,
   input  wire logic [vpt_pkg::COORD_W-1:0]   req_in_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [vpt_pkg::COORD_W-1:0]        rsp_out_x,
   output logic [vpt_pkg::COORD_W-1:0]        rsp_out_y,
   output logic [vpt_pkg::COORD_W-1:0]        rsp_out_z,
   output logic                               rsp_w_zero,
   output logic                               rsp_saturated
);
   import vpt_pkg::*;

   coef_bank_type coef_ff;
   logic          mac_ready;
   logic          div_valid [QUO_W+1];
   logic          div_ready [QUO_W+1];
   div_type       div_data  [QUO_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) coef_ff[i] <= REG_RESET[i];
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   vpt_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .coefs     (coef_ff),
      .in_valid  (req_valid),
      .in_ready  (mac_ready),
      .in_x      (req_in_x),
      .in_y      (req_in_y),
      .in_z      (req_in_z),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   assign req_stall = !mac_ready;

   // entry k produces quotient bit QUO_W-1-k
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      vpt_div_step #(.BIT(QUO_W-1-k)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_ready  (div_ready[k]),
         .in_data   (div_data[k]),
         .out_valid (div_valid[k+1]),
         .out_ready (div_ready[k+1]),
         .out_data  (div_data[k+1])
      );
   end

   vpt_sat u_sat (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (div_valid[QUO_W]),
      .in_ready      (div_ready[QUO_W]),
      .in_data       (div_data[QUO_W]),
      .out_valid     (rsp_valid),
      .out_ready     (!rsp_stall),
      .out_x         (rsp_out_x),
      .out_y         (rsp_out_y),
      .out_z         (rsp_out_z),
      .out_w_zero    (rsp_w_zero),
      .out_saturated (rsp_saturated)
   );

endmodule

`default_nettype wire
